[sv/pcihb_pkg.sv]
// Shared types, register offsets, opcodes and reset contents for the host-bridge
// configuration space. No dependencies.
package pcihb_pkg;

	localparam int unsigned REG_COUNT = 256;
	localparam int unsigned ADDR_W    = $clog2(REG_COUNT);

	localparam logic [1:0] OP_READ       = 2'd0;
	localparam logic [1:0] OP_WRITE      = 2'd1;
	localparam logic [1:0] OP_SOFT_RESET = 2'd2;

	localparam logic [7:0] ADDR_CMD_LO  = 8'h04;
	localparam logic [7:0] ADDR_CMD_HI  = 8'h05;
	localparam logic [7:0] ADDR_STS_LO  = 8'h06;
	localparam logic [7:0] ADDR_STS_HI  = 8'h07;
	localparam logic [7:0] ADDR_PAM0    = 8'h59;
	localparam logic [7:0] ADDR_PAM1    = 8'h5a;
	localparam logic [7:0] ADDR_PAM6    = 8'h5f;
	localparam logic [7:0] ADDR_RO_LO   = 8'h10;
	localparam logic [7:0] ADDR_RO_HI   = 8'h4e;

	localparam logic [7:0] CMD_LO_MASK  = 8'h42;
	localparam logic [7:0] CMD_LO_SET   = 8'h04;
	localparam logic [7:0] CMD_HI_MASK  = 8'h01;
	localparam logic [7:0] STS_HI_VAL   = 8'h02;
	localparam logic [7:0] NO_FUNC_BYTE = 8'hff;

	localparam logic [19:0] PAM0_BASE  = 20'hf0000;
	localparam logic [16:0] SIZE_64K   = 17'h10000;
	localparam logic [16:0] SIZE_16K   = 17'h04000;
	localparam logic [1:0]  PAMX_BASE_TOP = 2'b11;   // 0xC0000 region

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        map_valid;
		logic [19:0] region_base;
		logic [16:0] region_size;
		logic        read_internal;
		logic        write_internal;
		logic        bios_shadowed;
		logic        last_result;
	} result_t;

	function automatic logic [7:0] reg_default(input logic variant, input logic [ADDR_W-1:0] addr);
		logic [7:0] v;
		v = 8'h00;
		case (addr)
			8'h00: v = 8'h86;
			8'h01: v = 8'h80;
			8'h02: v = 8'ha3;
			8'h03: v = 8'h04;
			8'h04: v = 8'h06;
			8'h07: v = 8'h02;
			8'h08: v = variant ? 8'h10 : 8'h03;
			8'h0b: v = 8'h06;
			8'h50: v = variant ? 8'ha0 : 8'h80;
			8'h52: v = variant ? 8'h44 : 8'h40;
			8'h57: v = 8'h31;
			8'h60, 8'h61, 8'h62, 8'h63, 8'h64: v = 8'h02;
			8'h66, 8'h67: v = variant ? 8'h02 : 8'h00;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

[sv/pcihb_req_if.sv]
// Request channel: one configuration access per transaction.
// No dependencies.
interface pcihb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [2:0] function_number;
	logic [7:0] reg_offset;
	logic [7:0] write_byte;

	modport source (output valid, opcode, function_number, reg_offset, write_byte, input ready);
	modport sink   (input valid, opcode, function_number, reg_offset, write_byte, output ready);
endinterface

[sv/pcihb_rsp_if.sv]
// Response channel: read data and region-attribute events, one or two per transaction.
// No dependencies.
interface pcihb_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_byte;
	logic        map_valid;
	logic [19:0] region_base;
	logic [16:0] region_size;
	logic        read_internal;
	logic        write_internal;
	logic        bios_shadowed;
	logic        last_result;

	modport source (output valid, read_byte, map_valid, region_base, region_size,
		read_internal, write_internal, bios_shadowed, last_result, input ready);
	modport sink   (input valid, read_byte, map_valid, region_base, region_size,
		read_internal, write_internal, bios_shadowed, last_result, output ready);
endinterface

[sv/pcihb_store.sv]
// Configuration byte store: RAM with per-entry valid bits, registered read,
// write-to-read bypass and variant reset contents. Depends on pcihb_pkg.
module pcihb_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      variant,
	input  logic                      rd_en,
	input  logic [pcihb_pkg::ADDR_W-1:0] rd_addr,
	input  pcihb_pkg::wr_req_t        wr,
	output logic [7:0]                rd_data
);
	import pcihb_pkg::*;

	logic [7:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [7:0]          mem_rd_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic                vld_rd_q;
	logic                byp_hit_q;
	logic [7:0]          byp_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			rd_addr_q  <= rd_addr;
			byp_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_q  <= 1'b0;
			byp_hit_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q  <= vld_q[rd_addr];
				byp_hit_q <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	assign rd_data = byp_hit_q ? byp_data_q :
		(vld_rd_q ? mem_rd_q : reg_default(variant, rd_addr_q));

endmodule

[sv/pci_host_bridge_config_space.sv]
// Host-bridge configuration space: access filtering and PAM region events.
// Depends on pcihb_pkg, pcihb_req_if, pcihb_rsp_if and pcihb_store.
// A request is registered in the s1 stage, then its result in the output register.
// One request per cycle unless stalled; a two-event write holds the output until both are taken.
// The limit is the output stage, which emits one result per cycle while the receiver is ready.
// Reset clears control state and the store's valid bits; contents read as variant defaults.
module pci_host_bridge_config_space (
	input  logic clk,
	input  logic arst_n,
	pcihb_req_if.sink   req,
	pcihb_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic cfg_wdata
);
	import pcihb_pkg::*;

	logic              variant_q;
	logic              shadow_q;

	logic              valid_s1;
	logic [1:0]        op_s1;
	logic              func_zero_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        data_s1;

	logic              ob_valid_q;
	logic              ob_sel_q;
	result_t           ob_res0_q;
	result_t           ob_res1_q;
	result_t           cur;

	logic              accept;
	logic              advance;
	logic              ob_free;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        old;
	wr_req_t           wr;

	logic              is_wr;
	logic              dropped;
	logic [7:0]        val;
	logic [7:0]        diff;
	logic              lo_chg;
	logic              hi_chg;
	logic              is_pam0;
	logic              is_pamx;
	logic [2:0]        pam_idx;
	logic              shadow_nx;
	result_t           ev_lo;
	result_t           ev_hi;
	result_t           res0;
	result_t           res1;

	assign rd_addr = (req.opcode == OP_SOFT_RESET) ? ADDR_PAM0 : req.reg_offset;

	pcihb_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_we),
		.variant (variant_q),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_data (old)
	);

	assign cur     = ob_sel_q ? ob_res1_q : ob_res0_q;
	assign ob_free = !ob_valid_q || (rsp.ready && cur.last_result);
	assign advance = valid_s1 && ob_free;
	assign req.ready = !valid_s1 || ob_free;
	assign accept  = req.valid && req.ready;

	always_comb begin
		is_wr   = func_zero_s1 && (op_s1 == OP_WRITE || op_s1 == OP_SOFT_RESET);
		dropped = (addr_s1 inside {[ADDR_RO_LO:ADDR_RO_HI]}) ||
			(addr_s1 inside {8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0a, 8'h0b,
				8'h0c, 8'h0e});
		case (addr_s1)
			ADDR_CMD_LO: val = (data_s1 & CMD_LO_MASK) | CMD_LO_SET;
			ADDR_CMD_HI: val = data_s1 & CMD_HI_MASK;
			ADDR_STS_LO: val = 8'h00;
			ADDR_STS_HI: val = STS_HI_VAL;
			default:     val = data_s1;
		endcase
		diff    = old ^ val;
		is_pam0 = is_wr && (addr_s1 == ADDR_PAM0);
		is_pamx = is_wr && (addr_s1 inside {[ADDR_PAM1:ADDR_PAM6]});
		lo_chg  = diff[3:0] != 4'h0;
		hi_chg  = diff[7:4] != 4'h0;
		pam_idx = addr_s1[2:0] - 3'd2;
		shadow_nx = (is_pam0 && hi_chg) ? val[4] : shadow_q;

		ev_lo = '0;
		ev_lo.map_valid      = 1'b1;
		ev_lo.region_base    = {PAMX_BASE_TOP, pam_idx, 1'b0, 14'd0};
		ev_lo.region_size    = SIZE_16K;
		ev_lo.read_internal  = val[0];
		ev_lo.write_internal = val[1];
		ev_lo.bios_shadowed  = shadow_nx;

		ev_hi = ev_lo;
		ev_hi.region_base    = is_pam0 ? PAM0_BASE : {PAMX_BASE_TOP, pam_idx, 1'b1, 14'd0};
		ev_hi.region_size    = is_pam0 ? SIZE_64K : SIZE_16K;
		ev_hi.read_internal  = val[4];
		ev_hi.write_internal = val[5];

		res0 = '0;
		res0.bios_shadowed = shadow_nx;
		res0.last_result   = 1'b1;
		if (op_s1 == OP_READ) begin
			res0.read_byte = func_zero_s1 ? old : NO_FUNC_BYTE;
		end
		res1 = ev_hi;
		res1.last_result = 1'b1;

		if (is_pam0 && hi_chg) begin
			res0 = ev_hi;
			res0.last_result = 1'b1;
		end else if (is_pamx && (lo_chg || hi_chg)) begin
			res0 = lo_chg ? ev_lo : ev_hi;
			res0.last_result = !(lo_chg && hi_chg);
		end

		wr.en   = advance && is_wr && !dropped;
		wr.addr = addr_s1;
		wr.data = val;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= req.opcode;
			func_zero_s1 <= (req.opcode == OP_SOFT_RESET) || (req.function_number == 3'd0);
			addr_s1      <= rd_addr;
			data_s1      <= (req.opcode == OP_SOFT_RESET) ? 8'h00 : req.write_byte;
		end
		if (advance) begin
			ob_res0_q <= res0;
			ob_res1_q <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q  <= 1'b0;
			shadow_q   <= 1'b0;
			valid_s1   <= 1'b0;
			ob_valid_q <= 1'b0;
			ob_sel_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				variant_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				shadow_q   <= shadow_nx;
				ob_valid_q <= 1'b1;
				ob_sel_q   <= 1'b0;
			end else if (ob_valid_q && rsp.ready) begin
				if (cur.last_result) begin
					ob_valid_q <= 1'b0;
				end else begin
					ob_sel_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.valid          = ob_valid_q;
	assign rsp.read_byte      = cur.read_byte;
	assign rsp.map_valid      = cur.map_valid;
	assign rsp.region_base    = cur.region_base;
	assign rsp.region_size    = cur.region_size;
	assign rsp.read_internal  = cur.read_internal;
	assign rsp.write_internal = cur.write_internal;
	assign rsp.bios_shadowed  = cur.bios_shadowed;
	assign rsp.last_result    = cur.last_result;

endmodule

[sim/pci_host_bridge_config_space_test.sv]
// Testbench for pci_host_bridge_config_space: directed and random configuration accesses,
// checked against an in-bench predictor of the register image, shadow flag and PAM events.
// Depends on pcihb_pkg, pcihb_req_if, pcihb_rsp_if and the RTL under sv/.
module pci_host_bridge_config_space_test;
	import pcihb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  OP_UNUSED       = 2'd3;
	localparam logic [7:0]  ADDR_DEVICE_HI  = 8'h03;
	localparam logic [7:0]  ADDR_REV_ID     = 8'h08;
	localparam logic [7:0]  ADDR_CACHE_LINE = 8'h0c;
	localparam logic [7:0]  ADDR_HDR_TYPE   = 8'h0e;
	localparam logic [7:0]  ADDR_LAST       = 8'hff;
	localparam logic [19:0] PAMX_BASE       = 20'hc0000;
	localparam logic [19:0] PAM_STRIDE      = 20'h08000;
	localparam int          CYCLE_LIMIT     = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	pcihb_req_if req_ch();
	pcihb_rsp_if rsp_ch();

	pci_host_bridge_config_space u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [7:0] cfg_image [REG_COUNT];
	logic       shadow_bios;
	result_t    bridge_responses [$];

	int idle_pct;
	int stall_pct;
	int hold_left;
	int fails;
	int cycle_count;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic load_reset_image(input logic variant);
		foreach (cfg_image[i])
			cfg_image[i] = 8'h00;
		cfg_image[8'h00] = 8'h86; cfg_image[8'h01] = 8'h80;
		cfg_image[8'h02] = 8'ha3; cfg_image[8'h03] = 8'h04;
		cfg_image[8'h04] = 8'h06; cfg_image[8'h07] = 8'h02;
		cfg_image[8'h0b] = 8'h06; cfg_image[8'h57] = 8'h31;
		for (int a = 8'h60; a <= 8'h64; a++)
			cfg_image[a] = 8'h02;
		if (variant) begin
			cfg_image[8'h08] = 8'h10; cfg_image[8'h50] = 8'ha0;
			cfg_image[8'h52] = 8'h44;
			cfg_image[8'h66] = 8'h02; cfg_image[8'h67] = 8'h02;
		end else begin
			cfg_image[8'h08] = 8'h03; cfg_image[8'h50] = 8'h80;
			cfg_image[8'h52] = 8'h40;
		end
	endtask

	function automatic result_t pam_event(input logic [19:0] base, input logic [16:0] size,
		input logic [3:0] nib);
		result_t r;
		r = '0;
		r.map_valid      = 1'b1;
		r.region_base    = base;
		r.region_size    = size;
		r.read_internal  = nib[0];
		r.write_internal = nib[1];
		return r;
	endfunction

	// updates the register image and queues the responses one access produces
	task automatic apply_access(input logic [1:0] op, input logic [2:0] fn,
		input logic [7:0] off, input logic [7:0] data);
		result_t    events [$];
		result_t    r;
		logic [7:0] addr;
		logic [7:0] val;
		logic [7:0] old;
		logic [7:0] rd;
		logic [19:0] base;
		bit         drop;
		rd = 8'h00;
		drop = 1'b1;
		addr = off;
		val = data;
		if (op == OP_SOFT_RESET) begin
			addr = ADDR_PAM0;
			val = 8'h00;
			drop = 1'b0;
		end else if (op == OP_WRITE && fn == 3'd0) begin
			drop = 1'b0;
		end else if (op == OP_READ) begin
			rd = (fn != 3'd0) ? NO_FUNC_BYTE : cfg_image[off];
		end
		if (addr <= ADDR_DEVICE_HI || (addr >= ADDR_REV_ID && addr <= ADDR_CACHE_LINE) ||
				addr == ADDR_HDR_TYPE || (addr >= ADDR_RO_LO && addr <= ADDR_RO_HI))
			drop = 1'b1;
		if (!drop) begin
			old = cfg_image[addr];
			case (addr)
				ADDR_CMD_LO: val = (val & CMD_LO_MASK) | CMD_LO_SET;
				ADDR_CMD_HI: val = val & CMD_HI_MASK;
				ADDR_STS_LO: val = 8'h00;
				ADDR_STS_HI: val = STS_HI_VAL;
				ADDR_PAM0: begin
					if (old[7:4] != val[7:4]) begin
						events.push_back(pam_event(PAM0_BASE, SIZE_64K, val[7:4]));
						shadow_bios = val[4];
					end
				end
				default: begin
					if (addr >= ADDR_PAM1 && addr <= ADDR_PAM6) begin
						base = PAMX_BASE + 20'(addr - ADDR_PAM1) * PAM_STRIDE;
						if (old[3:0] != val[3:0])
							events.push_back(pam_event(base, SIZE_16K, val[3:0]));
						if (old[7:4] != val[7:4])
							events.push_back(pam_event(base + 20'(SIZE_16K), SIZE_16K,
								val[7:4]));
					end
				end
			endcase
			cfg_image[addr] = val;
		end
		if (events.size() == 0) begin
			r = '0;
			r.read_byte = rd;
			events.push_back(r);
		end
		foreach (events[k]) begin
			events[k].bios_shadowed = shadow_bios;
			events[k].last_result = (k == events.size() - 1);
			bridge_responses.push_back(events[k]);
		end
	endtask

	task automatic compare_field(input string name, input logic [19:0] want,
		input logic [19:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(negedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			if (bridge_responses.size() == 0) begin
				$error("response with none outstanding: read_byte %0h map_valid %0b",
					rsp_ch.read_byte, rsp_ch.map_valid);
				fails++;
			end else begin
				want = bridge_responses.pop_front();
				compare_field("read_byte", 20'(want.read_byte), 20'(rsp_ch.read_byte));
				compare_field("map_valid", 20'(want.map_valid), 20'(rsp_ch.map_valid));
				compare_field("region_base", want.region_base, rsp_ch.region_base);
				compare_field("region_size", 20'(want.region_size),
					20'(rsp_ch.region_size));
				compare_field("read_internal", 20'(want.read_internal),
					20'(rsp_ch.read_internal));
				compare_field("write_internal", 20'(want.write_internal),
					20'(rsp_ch.write_internal));
				compare_field("bios_shadowed", 20'(want.bios_shadowed),
					20'(rsp_ch.bios_shadowed));
				compare_field("last_result", 20'(want.last_result),
					20'(rsp_ch.last_result));
			end
		end
	end

	// called at a rising edge; returns at the edge where the transaction is taken
	task automatic send_access(input logic [1:0] op, input logic [2:0] fn,
		input logic [7:0] off, input logic [7:0] data);
		int gap;
		bit taken;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.function_number <= fn;
		req_ch.reg_offset <= off;
		req_ch.write_byte <= data;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_ch.ready;
			if (taken)
				apply_access(op, fn, off, data);
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (bridge_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_variant(input logic variant);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= variant;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_reset_image(variant);
	endtask

	task automatic run_random_accesses(input int count);
		logic [1:0] op;
		logic [2:0] fn;
		logic [7:0] off;
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			op = (pick < 35) ? OP_READ : (pick < 85) ? OP_WRITE :
				(pick < 93) ? OP_SOFT_RESET : OP_UNUSED;
			fn = ($urandom_range(99) < 85) ? 3'd0 : 3'($urandom_range(7, 1));
			pick = $urandom_range(99);
			if (pick < 45)
				off = 8'($urandom_range(ADDR_PAM6, ADDR_PAM0));
			else if (pick < 60)
				off = 8'($urandom_range(8'h0f, 0));
			else
				off = 8'($urandom_range(255));
			send_access(op, fn, off, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		set_variant(1'b0);
		send_access(OP_READ, 3'd0, 8'h00, 8'h00);
		send_access(OP_READ, 3'd0, ADDR_REV_ID, 8'hff);
		send_access(OP_WRITE, 3'd0, 8'h00, 8'h12);
		send_access(OP_READ, 3'd0, 8'h00, 8'h00);
		send_access(OP_WRITE, 3'd0, ADDR_RO_LO, 8'hff);
		send_access(OP_WRITE, 3'd0, ADDR_RO_HI, 8'hff);
		send_access(OP_WRITE, 3'd0, 8'h4f, 8'hff);
		send_access(OP_READ, 3'd0, 8'h4f, 8'h00);
		send_access(OP_WRITE, 3'd0, ADDR_CMD_LO, 8'hff);
		send_access(OP_READ, 3'd0, ADDR_CMD_LO, 8'h00);
		send_access(OP_WRITE, 3'd0, ADDR_CMD_HI, 8'hff);
		send_access(OP_WRITE, 3'd0, ADDR_STS_LO, 8'hff);
		send_access(OP_WRITE, 3'd0, ADDR_STS_HI, 8'h00);
		send_access(OP_READ, 3'd0, ADDR_STS_HI, 8'h00);
		send_access(OP_WRITE, 3'd0, ADDR_PAM0, 8'h30);
		send_access(OP_WRITE, 3'd0, ADDR_PAM0, 8'h3f);
		send_access(OP_WRITE, 3'd0, ADDR_PAM1, 8'hff);
		send_access(OP_WRITE, 3'd0, ADDR_PAM6, 8'h0f);
		send_access(OP_SOFT_RESET, 3'd7, ADDR_LAST, 8'hff);
		send_access(OP_READ, 3'd7, ADDR_LAST, 8'h00);
		send_access(OP_WRITE, 3'd7, ADDR_PAM1, 8'h00);
		send_access(OP_UNUSED, 3'd7, ADDR_LAST, 8'hff);
		send_access(OP_WRITE, 3'd0, ADDR_LAST, 8'hff);
		send_access(OP_READ, 3'd0, ADDR_LAST, 8'h00);
	endtask

	task automatic test_back_to_back();
		set_variant(1'b1);
		idle_pct = 0;
		stall_pct = 0;
		run_random_accesses(400);
	endtask

	task automatic test_sender_gaps();
		set_variant(1'b0);
		idle_pct = 70;
		stall_pct = 0;
		run_random_accesses(350);
	endtask

	task automatic test_receiver_stalls();
		set_variant(1'b1);
		idle_pct = 0;
		stall_pct = 70;
		run_random_accesses(350);
	endtask

	task automatic test_both_idle();
		set_variant(1'b1);
		idle_pct = 8;
		stall_pct = 8;
		run_random_accesses(350);
	endtask

	task automatic test_backpressure();
		set_variant(1'b0);
		idle_pct = 0;
		stall_pct = 0;
		hold_left <= 250;
		run_random_accesses(200);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_READ;
		req_ch.function_number = 3'd0;
		req_ch.reg_offset = 8'h00;
		req_ch.write_byte = 8'h00;
		rsp_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		fails = 0;
		cycle_count = 0;
		shadow_bios = 1'b0;
		load_reset_image(1'b0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fails == 0 && bridge_responses.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
